// ----- hdl/sba_pkg.sv -----
package sba_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] sun_x;
    logic signed [31:0] sun_y;
    logic signed [31:0] sun_z;
  } in_t;

  typedef struct packed {
    logic signed [17:0] beta;
    logic [1:0]         status;
  } out_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SMALL_H = 2'd1;
  localparam logic [1:0] ST_SMALL_S = 2'd2;
  localparam logic [1:0] ST_DIS     = 2'd3;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_HMIN   = 2'd1;
  localparam logic [1:0] CFG_SMIN   = 2'd2;

  localparam int THR_W = 63;

  // Multiply schedule: cross product, squared norms, dot and norms, den, q squared.
  localparam logic [4:0] MI_CROSS_END = 5'd11;
  localparam logic [4:0] MI_DOT_END   = 5'd20;
  localparam logic [4:0] MI_DEN       = 5'd21;
  localparam logic [4:0] MI_QSQ       = 5'd22;

  localparam logic [4:0] SQ_SRC_HH = 5'd0;
  localparam logic [4:0] SQ_SRC_SS = 5'd1;
  localparam logic [4:0] SQ_SRC_C  = 5'd2;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd29;
  localparam logic [4:0] CORD_LAST = 5'd29;

  localparam logic signed [33:0] BETA_MAX = 34'sd131071;
  localparam logic signed [33:0] BETA_MIN = -34'sd131072;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_ACC, OP_NORM_INIT, OP_NORM_STEP,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP,
    OP_CORD_INIT, OP_CORD_STEP, OP_FIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic small_h;
    logic small_s;
    logic norm_done;
    logic den_zero;
    logic out_free;
  } sts_t;

  function automatic logic [30:0] atan_q30(logic [4:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'h3243F6A8;
      5'd1:  r = 31'h1DAC6705;
      5'd2:  r = 31'h0FADBAFC;
      5'd3:  r = 31'h07F56EA6;
      5'd4:  r = 31'h03FEAB76;
      5'd5:  r = 31'h01FFD55B;
      5'd6:  r = 31'h00FFFAAA;
      5'd7:  r = 31'h007FFF55;
      5'd8:  r = 31'h003FFFEA;
      5'd9:  r = 31'h001FFFFD;
      5'd10: r = 31'h000FFFFF;
      5'd11: r = 31'h0007FFFF;
      5'd12: r = 31'h0003FFFF;
      5'd13: r = 31'h0001FFFF;
      5'd14: r = 31'h0000FFFF;
      5'd15: r = 31'h00007FFF;
      5'd16: r = 31'h00003FFF;
      5'd17: r = 31'h00001FFF;
      5'd18: r = 31'h00000FFF;
      5'd19: r = 31'h000007FF;
      5'd20: r = 31'h000003FF;
      5'd21: r = 31'h000001FF;
      5'd22: r = 31'h000000FF;
      5'd23: r = 31'h0000007F;
      5'd24: r = 31'h0000003F;
      5'd25: r = 31'h0000001F;
      5'd26: r = 31'h0000000F;
      5'd27: r = 31'h00000008;
      5'd28: r = 31'h00000004;
      5'd29: r = 31'h00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/sba_ctrl.sv -----
module sba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sba_pkg::sts_t sts_i,
  output sba_pkg::cmd_t cmd_o
);
  import sba_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_DOT   = 4'd4;
  localparam logic [3:0] S_SQH   = 4'd5;
  localparam logic [3:0] S_SQS   = 4'd6;
  localparam logic [3:0] S_DEN   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_QSQ   = 4'd9;
  localparam logic [3:0] S_SQC   = 4'd10;
  localparam logic [3:0] S_CORD  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [4:0] midx_q, midx_d;
  logic [4:0] cnt_q, cnt_d;
  logic       ph_q, ph_d;
  logic [1:0] code_q, code_d;

  logic [4:0] last;
  logic [3:0] nxt;
  op_e        op_init, op_step;
  logic [4:0] sel;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    last    = MI_CROSS_END;
    nxt     = S_IDLE;
    op_init = OP_SQRT_INIT;
    op_step = OP_SQRT_STEP;
    sel     = SQ_SRC_HH;
    unique case (state_q)
      S_CROSS: begin last = MI_CROSS_END; nxt = S_CHECK; end
      S_DOT:   begin last = MI_DOT_END;   nxt = S_SQH;   end
      S_DEN:   begin last = MI_DEN;       nxt = S_DIV;   end
      S_QSQ:   begin last = MI_QSQ;       nxt = S_SQC;   end
      S_SQH:   begin last = SQRT_LAST; nxt = S_SQS; sel = SQ_SRC_HH; end
      S_SQS:   begin last = SQRT_LAST; nxt = S_DEN; sel = SQ_SRC_SS; end
      S_SQC:   begin last = SQRT_LAST; nxt = S_CORD; sel = SQ_SRC_C; end
      S_DIV: begin
        last = DIV_LAST; nxt = S_QSQ; op_init = OP_DIV_INIT; op_step = OP_DIV_STEP;
      end
      S_CORD: begin
        last = CORD_LAST; nxt = S_DONE; op_init = OP_CORD_INIT; op_step = OP_CORD_STEP;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    midx_d  = midx_q;
    cnt_d   = cnt_q;
    ph_d    = ph_q;
    code_d  = code_q;
    cmd_o   = '{op: OP_NOP, idx: '0, code: code_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          midx_d   = '0;
          ph_d     = 1'b0;
          if (!sts_i.enable) begin
            code_d  = ST_DIS;
            state_d = S_DONE;
          end else begin
            state_d = S_CROSS;
          end
        end
      end
      S_CROSS, S_DOT, S_DEN, S_QSQ: begin
        cmd_o.idx = midx_q;
        if (!ph_q) begin
          cmd_o.op = OP_MUL;
          ph_d     = 1'b1;
        end else begin
          cmd_o.op = OP_ACC;
          ph_d     = 1'b0;
          midx_d   = midx_q + 5'd1;
          if (midx_q == last) state_d = nxt;
        end
      end
      S_CHECK: begin
        if (sts_i.small_h) begin
          code_d  = ST_SMALL_H;
          state_d = S_DONE;
        end else if (sts_i.small_s) begin
          code_d  = ST_SMALL_S;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_NORM_INIT;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (sts_i.norm_done) state_d = S_DOT;
        else cmd_o.op = OP_NORM_STEP;
      end
      S_SQH, S_SQS, S_SQC, S_DIV, S_CORD: begin
        if (!ph_q) begin
          // A zero denominator means a zero vector was let through: the angle is zero.
          if (state_q == S_DIV && sts_i.den_zero) begin
            code_d  = ST_OK;
            state_d = S_DONE;
          end else begin
            cmd_o.op  = op_init;
            cmd_o.idx = sel;
            ph_d      = 1'b1;
            cnt_d     = '0;
          end
        end else begin
          cmd_o.op  = op_step;
          cmd_o.idx = cnt_q;
          cnt_d     = cnt_q + 5'd1;
          if (cnt_q == last) begin
            ph_d    = 1'b0;
            state_d = nxt;
            code_d  = ST_OK;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      midx_q  <= '0;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      midx_q  <= midx_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      code_q  <= code_d;
    end
  end

endmodule

// ----- hdl/sba_dp.sv -----
module sba_dp #(
  parameter int COORD_BITS      = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [62:0]   cfg_data_i,
  input  sba_pkg::in_t  in_data_i,
  input  sba_pkg::cmd_t cmd_i,
  output sba_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sba_pkg::out_t out_data_o
);
  import sba_pkg::*;

  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam int XS = 32 - COORD_BITS;

  function automatic logic signed [31:0] sext(logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << XS);
    return t >>> XS;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [32:0] mk(logic neg, logic [29:0] m);
    logic signed [32:0] t;
    t = $signed({3'b000, m});
    return neg ? -t : t;
  endfunction

  function automatic logic ndone(logic [63:0] mx);
    return (mx[63:30] == '0) && (mx[29] || (mx == '0));
  endfunction

  logic              enable_q;
  logic [THR_W-1:0]  thr_h_q, thr_s_q;

  logic signed [31:0] p_q [3];
  logic signed [31:0] v_q [3];
  logic signed [31:0] s_q [3];
  logic signed [63:0] h_q [3];
  logic [63:0]        mh_q [3];
  logic [63:0]        ms_q [3];
  logic [2:0]         nh_q, ns_q;
  logic [63:0]        mxh_q, mxs_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_d, prod_q;
  logic [65:0]        acc_h_q, acc_s_q;
  logic signed [63:0] d_q;
  logic [63:0]        den_q;
  logic [31:0]        rh_q;

  logic [63:0] sq_n_q, sq_res_q, sq_bit, sq_t, sq_src;
  logic [63:0] rem_q, rem2, dm;
  logic [30:0] q_q;
  logic        skip_q;

  logic signed [33:0] x_q, y_q, dx, dy;
  logic signed [32:0] z_q, at;
  logic signed [33:0] zr, bz;
  logic signed [17:0] beta_q, beta_new;
  logic [1:0]         status_q;
  logic               out_valid_q;

  logic [63:0] mh0 [3];
  logic [63:0] ms0 [3];
  logic [63:0] mxh0, mxs0;
  logic        big_h;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mh0[i] = mag(h_q[i]);
      ms0[i] = mag(64'(s_q[i]));
    end
    mxh0 = mh0[0];
    if (mh0[1] > mxh0) mxh0 = mh0[1];
    if (mh0[2] > mxh0) mxh0 = mh0[2];
    mxs0 = ms0[0];
    if (ms0[1] > mxs0) mxs0 = ms0[1];
    if (ms0[2] > mxs0) mxs0 = ms0[2];
    big_h = (mh0[0][63:32] != '0) || (mh0[1][63:32] != '0) || (mh0[2][63:32] != '0);
  end

  // Shared multiplier operands, chosen by the schedule index.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.idx)
      5'd0:  begin mul_a = 33'(p_q[1]); mul_b = 33'(v_q[2]); end
      5'd1:  begin mul_a = 33'(p_q[2]); mul_b = 33'(v_q[1]); end
      5'd2:  begin mul_a = 33'(p_q[2]); mul_b = 33'(v_q[0]); end
      5'd3:  begin mul_a = 33'(p_q[0]); mul_b = 33'(v_q[2]); end
      5'd4:  begin mul_a = 33'(p_q[0]); mul_b = 33'(v_q[1]); end
      5'd5:  begin mul_a = 33'(p_q[1]); mul_b = 33'(v_q[0]); end
      5'd6, 5'd7, 5'd8: begin
        mul_a = $signed({1'b0, mh0[2'(cmd_i.idx - 5'd6)][31:0]});
        mul_b = mul_a;
      end
      5'd9, 5'd10, 5'd11: begin
        mul_a = 33'(s_q[2'(cmd_i.idx - 5'd9)]);
        mul_b = mul_a;
      end
      5'd12, 5'd13, 5'd14: begin
        mul_a = mk(nh_q[2'(cmd_i.idx - 5'd12)], mh_q[2'(cmd_i.idx - 5'd12)][29:0]);
        mul_b = mk(ns_q[2'(cmd_i.idx - 5'd12)], ms_q[2'(cmd_i.idx - 5'd12)][29:0]);
      end
      5'd15, 5'd16, 5'd17: begin
        mul_a = mk(nh_q[2'(cmd_i.idx - 5'd15)], mh_q[2'(cmd_i.idx - 5'd15)][29:0]);
        mul_b = mul_a;
      end
      5'd18, 5'd19, 5'd20: begin
        mul_a = mk(ns_q[2'(cmd_i.idx - 5'd18)], ms_q[2'(cmd_i.idx - 5'd18)][29:0]);
        mul_b = mul_a;
      end
      MI_DEN: begin
        mul_a = $signed({1'b0, rh_q});
        mul_b = $signed({1'b0, sq_res_q[31:0]});
      end
      MI_QSQ: begin
        mul_a = $signed({2'b00, q_q});
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    unique case (cmd_i.idx)
      SQ_SRC_HH: sq_src = acc_h_q[63:0];
      SQ_SRC_SS: sq_src = acc_s_q[63:0];
      default:   sq_src = (64'd1 << 60) - acc_h_q[63:0];
    endcase
    sq_bit = 64'd1 << (7'd62 - {1'b0, cmd_i.idx, 1'b0});
    sq_t   = sq_res_q + sq_bit;
    rem2   = rem_q << 1;
    dm     = mag(d_q);
    dx     = y_q >>> cmd_i.idx;
    dy     = x_q >>> cmd_i.idx;
    at     = $signed({2'b00, atan_q30(cmd_i.idx)});
    zr     = 34'(z_q) + 34'(1 << (SH - 1));
    bz     = zr >>> SH;
    if (den_q == '0) beta_new = '0;
    else if (bz > BETA_MAX) beta_new = BETA_MAX[17:0];
    else if (bz < BETA_MIN) beta_new = BETA_MIN[17:0];
    else beta_new = bz[17:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        p_q[0] <= sext(in_data_i.pos_x);
        p_q[1] <= sext(in_data_i.pos_y);
        p_q[2] <= sext(in_data_i.pos_z);
        v_q[0] <= sext(in_data_i.vel_x);
        v_q[1] <= sext(in_data_i.vel_y);
        v_q[2] <= sext(in_data_i.vel_z);
        s_q[0] <= sext(in_data_i.sun_x);
        s_q[1] <= sext(in_data_i.sun_y);
        s_q[2] <= sext(in_data_i.sun_z);
      end
      OP_MUL: prod_q <= prod_d;
      OP_ACC: begin
        unique case (cmd_i.idx)
          5'd0:  h_q[0] <= prod_q[63:0];
          5'd1:  h_q[0] <= h_q[0] - prod_q[63:0];
          5'd2:  h_q[1] <= prod_q[63:0];
          5'd3:  h_q[1] <= h_q[1] - prod_q[63:0];
          5'd4:  h_q[2] <= prod_q[63:0];
          5'd5:  h_q[2] <= h_q[2] - prod_q[63:0];
          5'd6, 5'd15:  acc_h_q <= prod_q;
          5'd7, 5'd8, 5'd16, 5'd17: acc_h_q <= acc_h_q + prod_q;
          5'd9, 5'd18:  acc_s_q <= prod_q;
          5'd10, 5'd11, 5'd19, 5'd20: acc_s_q <= acc_s_q + prod_q;
          5'd12: d_q <= prod_q[63:0];
          5'd13, 5'd14: d_q <= d_q + prod_q[63:0];
          MI_DEN: den_q <= prod_q[63:0];
          MI_QSQ: acc_h_q <= prod_q;
          default: ;
        endcase
      end
      OP_NORM_INIT: begin
        for (int i = 0; i < 3; i++) begin
          mh_q[i] <= mh0[i];
          ms_q[i] <= ms0[i];
          nh_q[i] <= h_q[i][63];
          ns_q[i] <= s_q[i][31];
        end
        mxh_q <= mxh0;
        mxs_q <= mxs0;
      end
      OP_NORM_STEP: begin
        // Each vector moves one bit a cycle until its largest part has 30 bits.
        if (mxh_q[63:30] != '0) begin
          for (int i = 0; i < 3; i++) mh_q[i] <= mh_q[i] >> 1;
          mxh_q <= mxh_q >> 1;
        end else if (!ndone(mxh_q)) begin
          for (int i = 0; i < 3; i++) mh_q[i] <= mh_q[i] << 1;
          mxh_q <= mxh_q << 1;
        end
        if (mxs_q[63:30] != '0) begin
          for (int i = 0; i < 3; i++) ms_q[i] <= ms_q[i] >> 1;
          mxs_q <= mxs_q >> 1;
        end else if (!ndone(mxs_q)) begin
          for (int i = 0; i < 3; i++) ms_q[i] <= ms_q[i] << 1;
          mxs_q <= mxs_q << 1;
        end
      end
      OP_SQRT_INIT: begin
        sq_n_q   <= sq_src;
        sq_res_q <= '0;
        if (cmd_i.idx == SQ_SRC_SS) rh_q <= sq_res_q[31:0];
      end
      OP_SQRT_STEP: begin
        if (sq_n_q >= sq_t) begin
          sq_n_q   <= sq_n_q - sq_t;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
      OP_DIV_INIT: begin
        rem_q <= dm;
        if (dm >= den_q) begin
          q_q    <= 31'd1 << 30;
          skip_q <= 1'b1;
        end else begin
          q_q    <= '0;
          skip_q <= 1'b0;
        end
      end
      OP_DIV_STEP: begin
        if (!skip_q) begin
          if (rem2 >= den_q) begin
            rem_q <= rem2 - den_q;
            q_q   <= {q_q[29:0], 1'b1};
          end else begin
            rem_q <= rem2;
            q_q   <= {q_q[29:0], 1'b0};
          end
        end
      end
      OP_CORD_INIT: begin
        x_q <= $signed({2'b00, sq_res_q[31:0]});
        y_q <= d_q[63] ? -$signed({3'b000, q_q}) : $signed({3'b000, q_q});
        z_q <= '0;
      end
      OP_CORD_STEP: begin
        if (!y_q[33]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      thr_h_q     <= THR_W'(1);
      thr_s_q     <= THR_W'(1);
      beta_q      <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENABLE: enable_q <= cfg_data_i[0];
          CFG_HMIN:   thr_h_q  <= cfg_data_i;
          CFG_SMIN:   thr_s_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
        status_q    <= cmd_i.code;
        if (cmd_i.code == ST_OK) beta_q <= beta_new;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.enable    = enable_q;
  assign sts_o.small_h   = !big_h && (acc_h_q < {3'b000, thr_h_q});
  assign sts_o.small_s   = acc_s_q < {3'b000, thr_s_q};
  assign sts_o.norm_done = ndone(mxh_q) && ndone(mxs_q);
  assign sts_o.den_zero  = (den_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign out_data_o.beta   = beta_q;
  assign out_data_o.status = status_q;

endmodule

// ----- hdl/solar_beta_angle.sv -----
// A checked item runs through the normalizing shifter and the bit-serial square root,
// divide and CORDIC loops; a rejected vector or a disabled block skips them.
// One item is in work at a time; the next input beat is taken once the result is in
// the output register.
// Reset clears the held angle to zero, enables the block and sets both thresholds to 1.
module solar_beta_angle #(
  parameter int COORD_BITS      = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [62:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sba_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sba_pkg::out_t  out_data_o
);
  import sba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sba_dp #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An accepted beat keeps the input side stalled while the item is in work.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A rejected or disabled result repeats the angle that was held before it.
  a_hold_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && out_data_o.status != ST_OK) |-> $stable(out_data_o.beta))
    else $error("held angle changed on a rejected result");

endmodule

// ----- sim/solar_beta_angle_tb.sv -----
`timescale 1ns / 100ps

module solar_beta_angle_tb;
  import sba_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int IDLE_WAIT   = 300;

  typedef longint vec3_t [3];

  class beta_scoreboard;
    bit                  enable_q;
    longint unsigned     hmin_q;
    longint unsigned     smin_q;
    logic signed [17:0]  held_beta;
    out_t                pending_q [$];
    int                  mismatches;

    function new();
      enable_q   = 1'b1;
      hmin_q     = 64'd1;
      smin_q     = 64'd1;
      held_beta  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [62:0] data);
      if (idx == CFG_ENABLE) enable_q = data[0];
      else if (idx == CFG_HMIN) hmin_q = {1'b0, data};
      else if (idx == CFG_SMIN) smin_q = {1'b0, data};
    endfunction

    function longint atan_entry(int i);
      case (i)
        0: return 64'h3243F6A8;   1: return 64'h1DAC6705;   2: return 64'h0FADBAFC;
        3: return 64'h07F56EA6;   4: return 64'h03FEAB76;   5: return 64'h01FFD55B;
        6: return 64'h00FFFAAA;   7: return 64'h007FFF55;   8: return 64'h003FFFEA;
        9: return 64'h001FFFFD;  10: return 64'h000FFFFF;  11: return 64'h0007FFFF;
        12: return 64'h0003FFFF; 13: return 64'h0001FFFF;  14: return 64'h0000FFFF;
        15: return 64'h00007FFF; 16: return 64'h00003FFF;  17: return 64'h00001FFF;
        18: return 64'h00000FFF; 19: return 64'h000007FF;  20: return 64'h000003FF;
        21: return 64'h000001FF; 22: return 64'h000000FF;  23: return 64'h0000007F;
        24: return 64'h0000003F; 25: return 64'h0000001F;  26: return 64'h0000000F;
        27: return 64'h00000008; 28: return 64'h00000004;  29: return 64'h00000002;
        default: return 64'd0;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      longint unsigned u;
      u = v;
      return (v < 0) ? (64'd0 - u) : u;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Squared magnitude with saturation; any component of 2^32 or more is never small.
    function bit is_small(vec3_t v, longint unsigned thr);
      longint unsigned acc, m, sq;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        m = mag(v[i]);
        if (m >= (64'd1 << 32)) return 1'b0;
        sq  = m * m;
        acc = (acc > ~sq) ? ~64'd0 : acc + sq;
      end
      return acc < thr;
    endfunction

    function void scale30(vec3_t v, output vec3_t o);
      longint unsigned mx, m;
      int nb;
      mx = 0;
      for (int i = 0; i < 3; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
      nb = 0;
      while (mx != 0) begin
        nb++;
        mx = mx >> 1;
      end
      for (int i = 0; i < 3; i++) begin
        m = mag(v[i]);
        if (nb > 30) m = m >> (nb - 30);
        else m = m << (30 - nb);
        o[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
      end
    endfunction

    function logic signed [17:0] solve_angle(vec3_t h, vec3_t s);
      vec3_t hn, sn;
      longint d, x, y, z, dx, dy, b;
      longint unsigned hh, ss, den, dm, q, rem;
      scale30(h, hn);
      scale30(s, sn);
      d = 0; hh = 0; ss = 0;
      for (int i = 0; i < 3; i++) begin
        d  += hn[i] * sn[i];
        hh += longint'(hn[i] * hn[i]);
        ss += longint'(sn[i] * sn[i]);
      end
      den = floor_sqrt(hh) * floor_sqrt(ss);
      if (den == 0) return '0;
      dm = mag(d);
      q  = 0;
      if (dm >= den) begin
        q = 64'd1 << 30;
      end else begin
        rem = dm;
        for (int i = 0; i < 30; i++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= den) begin
            rem = rem - den;
            q   = q | 64'd1;
          end
        end
      end
      x = floor_sqrt((64'd1 << 60) - q * q);
      y = (d < 0) ? -longint'(q) : longint'(q);
      z = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_entry(i);
        end else begin
          x -= dx; y += dy; z -= atan_entry(i);
        end
      end
      b = (z + 64'sd8192) >>> 14;
      if (b > 131071) b = 131071;
      if (b < -131072) b = -131072;
      return b[17:0];
    endfunction

    function void note_input(in_t it);
      vec3_t p, v, s, h;
      out_t exp_r;
      p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
      v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
      s = '{longint'(it.sun_x), longint'(it.sun_y), longint'(it.sun_z)};
      if (!enable_q) begin
        exp_r.status = ST_DIS;
      end else begin
        h[0] = p[1] * v[2] - p[2] * v[1];
        h[1] = p[2] * v[0] - p[0] * v[2];
        h[2] = p[0] * v[1] - p[1] * v[0];
        if (is_small(h, hmin_q)) exp_r.status = ST_SMALL_H;
        else if (is_small(s, smin_q)) exp_r.status = ST_SMALL_S;
        else begin
          exp_r.status = ST_OK;
          held_beta = solve_angle(h, s);
        end
      end
      exp_r.beta = held_beta;
      pending_q.push_back(exp_r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: beta %0d status %0d", got.beta, got.status);
        return;
      end
      want = pending_q.pop_front();
      if (got.beta !== want.beta || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected beta %0d status %0d, got beta %0d status %0d",
                   want.beta, want.status, got.beta, got.status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [62:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  beta_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  solar_beta_angle dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("solar_beta_angle_tb: errors");
      $finish;
    end
  end

  // Input and result beats are observed on the edge that moves them.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // The receiver switches at random among four stall behaviors.
  always @(posedge clk_i) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ((cycles % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 99) < 80);
    endcase
  end

  task automatic send(in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [62:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'($signed($urandom) >>> $urandom_range(0, 31));
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom) >>> 16);
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.pos_x = pick_coord(); it.pos_y = pick_coord(); it.pos_z = pick_coord();
    it.vel_x = pick_coord(); it.vel_y = pick_coord(); it.vel_z = pick_coord();
    it.sun_x = pick_coord(); it.sun_y = pick_coord(); it.sun_z = pick_coord();
    if ($urandom_range(0, 19) == 0) begin
      it.vel_x = it.pos_x; it.vel_y = it.pos_y; it.vel_z = it.pos_z;
    end
    if ($urandom_range(0, 19) == 0) it.sun_x = '0;
    if ($urandom_range(0, 19) == 0) begin
      it.sun_y = '0; it.sun_z = '0;
    end
    return it;
  endfunction

  function automatic in_t mk(int px, int py, int pz, int vx, int vy, int vz,
                             int sx, int sy, int sz);
    in_t it;
    it = '{px, py, pz, vx, vy, vz, sx, sy, sz};
    return it;
  endfunction

  function automatic logic [62:0] pick_thr();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 63'd1;
      2: return {63{1'b1}};
      default: return 63'd1 << $urandom_range(0, 62);
    endcase
  endfunction

  localparam int MN = 32'h8000_0000;
  localparam int MX = 32'h7FFF_FFFF;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under reset configuration.
    send(mk(0, 0, 0, 0, 0, 0, 5, 5, 5));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 0));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 5));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, -5));
    send(mk(1, 0, 0, 0, 1, 0, 7, 0, 0));
    send(mk(3, 4, 0, -4, 3, 2, 1, 1, 1));
    send(mk(MN, MN, MN, MN, MN, MN, MN, MN, MN));
    send(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    send(mk(MN, 0, MN, 0, MN, MX, MN, MX, MN));
    send(mk(0, MN, MN, MN, MX, MN, MX, MX, MX));
    send(mk(MX, 0, 0, 0, MN, 0, 0, 0, MN));
    send(mk(-1, -1, -1, 1, 2, 3, -1, -1, -1));
    send(mk(1000, 7, -3, 5, 999, 2, 123456, -654321, 42));

    // With zero thresholds, zero vectors pass the check and give a zero angle.
    write_reg(CFG_HMIN, '0);
    write_reg(CFG_SMIN, '0);
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 3));
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 0));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, -3));

    write_reg(CFG_ENABLE, 63'd0);
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 3));
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));

    write_reg(CFG_ENABLE, 63'd1);
    write_reg(CFG_HMIN, {63{1'b1}});
    send(mk(MN, MN, MX, MX, MN, MN, 1, 1, 1));
    write_reg(CFG_HMIN, 63'd1);
    write_reg(CFG_SMIN, {63{1'b1}});
    send(mk(1, 0, 0, 0, 1, 0, MN, MN, MN));
    send(mk(1, 0, 0, 0, 1, 0, 3, 3, 3));

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ENABLE, (ph == 5) ? 63'd0 : 63'd1);
      write_reg(CFG_HMIN, (ph < 2) ? 63'd1 : pick_thr());
      write_reg(CFG_SMIN, (ph < 2) ? 63'd1 : pick_thr());
      for (int k = 0; k < 75; k++) send(rand_item());
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("solar_beta_angle_tb: clean");
    end else begin
      $display("solar_beta_angle_tb: errors");
    end
    $finish;
  end

endmodule
